FILE: sv/multi_led_blink_timer_defines.svh
// Assertion macros shared by the multi-LED blink timer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MULTI_LED_BLINK_TIMER_DEFINES_SVH
`define MULTI_LED_BLINK_TIMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("multi_led_blink_timer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MLBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("multi_led_blink_timer: next-cycle check failed");

`endif

FILE: sv/mlbt_pkg.sv
// Package for the multi-LED blink timer: field widths, codes, entry layout.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package mlbt_pkg;

  localparam int CMD_W   = 1;
  localparam int LIDX_W  = 3;
  localparam int MODE_W  = 2;
  localparam int TIME_W  = 16;
  localparam int LEDS_W  = 8;

  localparam int NUM_LEDS_DEF = 8;

  localparam logic [CMD_W-1:0] CMD_TICK = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SET  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

  // One memory entry per LED: blink timing and the two time stamps.
  typedef struct packed {
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] toggle_stamp;
    logic [TIME_W-1:0] start_stamp;
  } entry_t;

endpackage

FILE: sv/mlbt_if.sv
// Valid/ready channel interfaces for the blink timer's command and status beats.
// Depends on mlbt_pkg for the field widths.
`timescale 1ns / 1ps

interface mlbt_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [mlbt_pkg::CMD_W-1:0]         cmd;
  logic [mlbt_pkg::LIDX_W-1:0]        led_index;
  logic [mlbt_pkg::MODE_W-1:0]        led_mode;
  logic [mlbt_pkg::TIME_W-1:0]        interval_ms;
  logic [mlbt_pkg::TIME_W-1:0]        duration_ms;

  modport source (output valid, cmd, led_index, led_mode, interval_ms, duration_ms,
                  input ready);
  modport sink   (input valid, cmd, led_index, led_mode, interval_ms, duration_ms,
                  output ready);
endinterface

interface mlbt_stat_if;
  logic                               valid;
  logic                               ready;
  logic [mlbt_pkg::LEDS_W-1:0]        led_levels;
  logic [mlbt_pkg::LEDS_W-1:0]        blinking_mask;

  modport source (output valid, led_levels, blinking_mask, input ready);
  modport sink   (input valid, led_levels, blinking_mask, output ready);
endinterface

FILE: sv/multi_led_blink_timer.sv
// Multi-LED blink timer: per-LED blink state in a synchronous one-write, one-read memory.
// Depends on mlbt_pkg, mlbt_if and multi_led_blink_timer_defines.svh.
//
//   channel | dir | beat contents
//   in_ch   | in  | cmd, led_index, led_mode, interval_ms, duration_ms
//   out_ch  | out | led_levels, blinking_mask (one beat per input beat)
//
// A set beat is applied in the accept cycle, then the status is loaded into the
// output register. A tick beat makes the scan walk the entry memory one LED per
// cycle (the read is registered, so a final scan step drains the last entry),
// then the status is loaded.
// Reset is synchronous and clears the counter, modes and levels; the memory needs
// no clearing since an entry is only evaluated after a blink set has written it.
// A stalled output holds the block in its final state until the beat is taken.
`timescale 1ns / 1ps

`include "multi_led_blink_timer_defines.svh"

module multi_led_blink_timer #(
  parameter int NUM_LEDS = mlbt_pkg::NUM_LEDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mlbt_cmd_if.sink     in_ch,
  mlbt_stat_if.source  out_ch
);
  import mlbt_pkg::*;

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CNT_W = $clog2(NUM_LEDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [NUM_LEDS-1:0] lit_r, lit_nxt;
  logic [MODE_W-1:0]   mode_r   [NUM_LEDS];
  logic [MODE_W-1:0]   mode_nxt [NUM_LEDS];
  logic [NUM_LEDS-1:0] blink_vec;

  logic                out_valid_r;
  logic [LEDS_W-1:0]   out_levels_r;
  logic [LEDS_W-1:0]   out_mask_r;

  entry_t              entry_mem [NUM_LEDS];
  entry_t              rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;

  logic                in_acc;
  logic                out_free;
  logic                idx_ok;
  logic [IDX_W-1:0]    set_idx;
  logic [IDX_W-1:0]    ev_idx;
  logic [TIME_W-1:0]   since_toggle;
  logic [TIME_W-1:0]   since_start;
  logic                do_toggle;
  logic                do_expire;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign idx_ok      = (32'(in_ch.led_index) < NUM_LEDS);
  assign set_idx     = in_ch.led_index[IDX_W-1:0];

  // Entry under evaluation is the one read in the previous scan cycle.
  assign ev_idx       = IDX_W'(cnt_r - CNT_W'(1));
  assign rd_addr      = (cnt_r < CNT_W'(NUM_LEDS)) ? cnt_r[IDX_W-1:0] : '0;
  assign since_toggle = now_r - rd_data_r.toggle_stamp;
  assign since_start  = now_r - rd_data_r.start_stamp;
  assign do_toggle    = (since_toggle >= rd_data_r.interval);
  assign do_expire    = (since_start >= rd_data_r.duration);

  // Blink mask from the mode flops.
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      blink_vec[i] = (mode_r[i] == MODE_BLINK);
    end
  end

  // Sequencer and read-modify-write of the per-LED entries.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    now_nxt   = now_r;
    lit_nxt   = lit_r;
    mode_nxt  = mode_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_TICK) begin
            now_nxt   = now_r + TIME_W'(1);
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            if (idx_ok) begin
              mode_nxt[set_idx] = in_ch.led_mode;
              if (in_ch.led_mode == MODE_OFF) begin
                lit_nxt[set_idx] = 1'b0;
              end else if (in_ch.led_mode == MODE_ON) begin
                lit_nxt[set_idx] = 1'b1;
              end else if (in_ch.led_mode == MODE_BLINK) begin
                lit_nxt[set_idx]     = 1'b1;
                wr_en                = 1'b1;
                wr_addr              = set_idx;
                wr_data.interval     = in_ch.interval_ms;
                wr_data.duration     = in_ch.duration_ms;
                wr_data.toggle_stamp = now_r;
                wr_data.start_stamp  = now_r;
              end
            end
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        // Toggle first, then expiry forces the LED dark.
        if (cnt_r != '0 && mode_r[ev_idx] == MODE_BLINK) begin
          if (do_toggle) begin
            lit_nxt[ev_idx]      = ~lit_r[ev_idx];
            wr_en                = 1'b1;
            wr_addr              = ev_idx;
            wr_data.toggle_stamp = now_r;
          end
          if (do_expire) begin
            mode_nxt[ev_idx] = MODE_OFF;
            lit_nxt[ev_idx]  = 1'b0;
          end
        end
        if (cnt_r == CNT_W'(NUM_LEDS)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Entry memory: one write and one registered read per cycle. The scan reads
  // entry k while writing entry k-1, and sets happen only outside the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= entry_mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      now_r   <= '0;
      lit_r   <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_r[i] <= MODE_OFF;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      now_r   <= now_nxt;
      lit_r   <= lit_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Output register holds the status beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_levels_r <= LEDS_W'(lit_r);
      out_mask_r   <= LEDS_W'(blink_vec);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.led_levels    = out_levels_r;
  assign out_ch.blinking_mask = out_mask_r;

  // Checks on the sequencer, counter, memory writes and output range.
  `MLBT_ASSERT_IMP(a_scan_cnt_bound, clk, rst_n, state_r == ST_SCAN, cnt_r <= CNT_W'(NUM_LEDS))
  `MLBT_ASSERT_NXT(a_tick_advances, clk, rst_n, in_acc && in_ch.cmd == CMD_TICK, now_r == $past(now_r) + TIME_W'(1) && state_r == ST_SCAN)
  `MLBT_ASSERT_NXT(a_fin_loads_out, clk, rst_n, state_r == ST_FIN && out_free, out_valid_r && state_r == ST_IDLE)
  `MLBT_ASSERT_IMP(a_wr_only_busy, clk, rst_n, wr_en, in_acc || (state_r == ST_SCAN && cnt_r != '0))
  `MLBT_ASSERT_IMP(a_out_range, clk, rst_n, out_valid_r, (out_levels_r >> NUM_LEDS) == '0 && (out_mask_r >> NUM_LEDS) == '0)

endmodule

FILE: tb/tb_multi_led_blink_timer.sv
// Self-checking testbench for multi_led_blink_timer: command beats in, status beats out.
// Depends on mlbt_pkg, the mlbt_cmd_if/mlbt_stat_if channels and the RTL top level.
`timescale 1ns / 1ps

module tb_multi_led_blink_timer;
  import mlbt_pkg::*;

  localparam int NUM_LEDS = NUM_LEDS_DEF;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  // A tick beat walks every LED entry, plus the read drain and the status load.
  localparam int SCAN_CYCLES = NUM_LEDS + 3;
  localparam int STUCK_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 250;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LIDX_W-1:0] led_index;
    logic [MODE_W-1:0] led_mode;
    logic [TIME_W-1:0] interval_ms;
    logic [TIME_W-1:0] duration_ms;
  } cmd_beat_t;

  typedef struct packed {
    logic [LEDS_W-1:0] led_levels;
    logic [LEDS_W-1:0] blinking_mask;
  } status_beat_t;

  // Tracks the LED state from accepted commands and checks the status beats.
  class led_status_predictor;
    logic [TIME_W-1:0] now_ms;
    logic [MODE_W-1:0] led_mode_r [NUM_LEDS];
    logic [TIME_W-1:0] interval_r [NUM_LEDS];
    logic [TIME_W-1:0] duration_r [NUM_LEDS];
    logic [TIME_W-1:0] toggle_at  [NUM_LEDS];
    logic [TIME_W-1:0] start_at   [NUM_LEDS];
    logic [LEDS_W-1:0] lit;
    status_beat_t      status_due_q [$];
    int                errors;

    function new();
      now_ms = '0;
      lit    = '0;
      errors = 0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode_r[i] = MODE_OFF;
        interval_r[i] = '0;
        duration_r[i] = '0;
        toggle_at[i]  = '0;
        start_at[i]   = '0;
      end
    endfunction

    // Apply one accepted command beat and queue the status it must produce.
    function void apply_command(cmd_beat_t b);
      logic [TIME_W-1:0] since;
      status_beat_t      s;
      if (b.cmd == CMD_TICK) begin
        now_ms = now_ms + 1'b1;
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (led_mode_r[i] == MODE_BLINK) begin
            // Toggle first; an expiry on the same tick then forces the LED dark.
            since = now_ms - toggle_at[i];
            if (since >= interval_r[i]) begin
              toggle_at[i] = now_ms;
              lit[i] = ~lit[i];
            end
            since = now_ms - start_at[i];
            if (since >= duration_r[i]) begin
              led_mode_r[i] = MODE_OFF;
              lit[i] = 1'b0;
            end
          end
        end
      end else if (b.led_index < NUM_LEDS) begin
        led_mode_r[b.led_index] = b.led_mode;
        unique case (b.led_mode)
          MODE_OFF: begin
            lit[b.led_index] = 1'b0;
          end
          MODE_ON: begin
            lit[b.led_index] = 1'b1;
          end
          MODE_BLINK: begin
            interval_r[b.led_index] = b.interval_ms;
            duration_r[b.led_index] = b.duration_ms;
            toggle_at[b.led_index]  = now_ms;
            start_at[b.led_index]   = now_ms;
            lit[b.led_index] = 1'b1;
          end
          default: begin
            // The reserved code is stored but leaves the level alone.
          end
        endcase
      end
      s = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        s.led_levels[i]    = lit[i];
        s.blinking_mask[i] = (led_mode_r[i] == MODE_BLINK);
      end
      status_due_q.push_back(s);
    endfunction

    // Compare one accepted status beat with the oldest pending status.
    function void compare_status(status_beat_t got);
      status_beat_t want;
      if (status_due_q.size() == 0) begin
        $display("%0t: unexpected status beat, expected none, actual levels %02h mask %02h",
                 $time, got.led_levels, got.blinking_mask);
        errors++;
        return;
      end
      want = status_due_q.pop_front();
      if (want.led_levels !== got.led_levels) begin
        $display("%0t: led_levels expected %02h, actual %02h",
                 $time, want.led_levels, got.led_levels);
        errors++;
      end
      if (want.blinking_mask !== got.blinking_mask) begin
        $display("%0t: blinking_mask expected %02h, actual %02h",
                 $time, want.blinking_mask, got.blinking_mask);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mlbt_cmd_if  in_ch ();
  mlbt_stat_if out_ch ();

  led_status_predictor predictor;
  int src_idle_pct;
  int rcv_stall_pct;
  int stuck_cycles;

  multi_led_blink_timer #(.NUM_LEDS(NUM_LEDS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready changes on the falling edge, stalling at the phase's rate.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= rcv_stall_pct);
  end

  // Status monitor: every accepted status beat is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      predictor.compare_status('{led_levels: out_ch.led_levels,
                                 blinking_mask: out_ch.blinking_mask});
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: watchdog expired, no beat for %0d cycles", $time, STUCK_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one command beat, with random idle cycles first, until it is taken.
  task automatic send_beat(cmd_beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.cmd         = b.cmd;
    in_ch.led_index   = b.led_index;
    in_ch.led_mode    = b.led_mode;
    in_ch.interval_ms = b.interval_ms;
    in_ch.duration_ms = b.duration_ms;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predictor.apply_command(b);
  endtask

  // A tick carries random content in the fields that it ignores.
  task automatic send_tick();
    cmd_beat_t b;
    b.cmd         = CMD_TICK;
    b.led_index   = LIDX_W'($urandom);
    b.led_mode    = MODE_W'($urandom);
    b.interval_ms = TIME_W'($urandom);
    b.duration_ms = TIME_W'($urandom);
    send_beat(b);
  endtask

  task automatic send_set(int idx, logic [MODE_W-1:0] mode,
                          logic [TIME_W-1:0] iv, logic [TIME_W-1:0] du);
    send_beat('{cmd: CMD_SET, led_index: idx[LIDX_W-1:0], led_mode: mode,
                interval_ms: iv, duration_ms: du});
  endtask

  // Hold the sender off until every pending status has come back.
  task automatic drain_status();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (predictor.status_due_q.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  // Pick a random blink time: mostly short, sometimes an extreme or anything.
  function automatic logic [TIME_W-1:0] pick_time(int short_max);
    int sel;
    sel = $urandom_range(9);
    unique case (sel)
      0: pick_time = '0;
      1: pick_time = '1;
      2: pick_time = TIME_W'($urandom);
      default: pick_time = TIME_W'($urandom_range(short_max));
    endcase
  endfunction

  // Random command: ticks mixed with sets, half of which start a mostly short blink.
  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int        r;
    b.cmd         = CMD_TICK;
    b.led_index   = LIDX_W'($urandom);
    b.led_mode    = MODE_W'($urandom);
    b.interval_ms = TIME_W'($urandom);
    b.duration_ms = TIME_W'($urandom);
    if ($urandom_range(99) >= 55) begin
      b.cmd = CMD_SET;
      r = $urandom_range(99);
      if (r < 50) begin
        b.led_mode    = MODE_BLINK;
        b.interval_ms = pick_time(12);
        b.duration_ms = pick_time(40);
      end else if (r < 70) begin
        b.led_mode = MODE_ON;
      end else if (r < 88) begin
        b.led_mode = MODE_OFF;
      end else begin
        b.led_mode = MODE_RESERVED;
      end
    end
    return b;
  endfunction

  initial begin
    predictor     = new();
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    stuck_cycles  = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.led_index   = '0;
    in_ch.led_mode    = MODE_OFF;
    in_ch.interval_ms = '0;
    in_ch.duration_ms = '0;
    out_ch.ready      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero interval and duration, reserved mode, extremes, stored timing kept.
    send_tick();
    send_set(0, MODE_BLINK, 16'd0, 16'd0);
    send_tick();
    send_set(1, MODE_BLINK, 16'd2, 16'd5);
    send_set(2, MODE_ON, 16'hFFFF, 16'hFFFF);
    send_set(3, MODE_RESERVED, 16'd0, 16'd0);
    send_set(2, MODE_RESERVED, 16'hFFFF, 16'h0000);
    repeat (6) send_tick();
    send_set(4, MODE_BLINK, 16'hFFFF, 16'hFFFF);
    send_set(5, MODE_BLINK, 16'd1, 16'hFFFF);
    send_set(2, MODE_OFF, 16'h5555, 16'hAAAA);
    send_set(7, MODE_ON, 16'hAAAA, 16'h5555);
    send_set(7, MODE_BLINK, 16'd0, 16'd3);
    repeat (3) send_tick();
    send_set(1, MODE_ON, 16'h1234, 16'h4321);
    send_set(6, MODE_BLINK, 16'd0, 16'd1);
    send_tick();
    drain_status();

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin src_idle_pct = 45; rcv_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rcv_stall_pct = 45; end
        default: begin src_idle_pct = 24; rcv_stall_pct = 24; end
      endcase
      repeat (RAND_PER_PHASE) send_beat(random_beat());
      drain_status();
    end

    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    drain_status();
    repeat (2 * SCAN_CYCLES) @(posedge clk);
    if (predictor.status_due_q.size() != 0) begin
      $display("%0t: %0d status beats still pending at the end",
               $time, predictor.status_due_q.size());
      predictor.errors++;
    end
    if (predictor.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
